FILE: hdl/sccw_pkg.sv
// Package for the script comment and whitespace stripper.
// Character codes, result slot types and shared widths; no dependencies.
package sccw_pkg;

    localparam int OFFSET_BITS_DEF = 24;   // default width of the output counter
    localparam int OUT_OFFSET_W    = 24;   // width of the offset field in a result
    localparam int NUM_SLOTS       = 5;    // most results one byte can cause

    localparam logic [7:0] CH_SEMI   = 8'h3B;  // ';'
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic [7:0]              data;
        logic [OUT_OFFSET_W-1:0] offset;
    } slot_t;

    // one input byte's results: slot i is present when mask[i] is set,
    // slots are delivered lowest first
    typedef struct packed {
        logic  [NUM_SLOTS-1:0] mask;
        slot_t [NUM_SLOTS-1:0] slots;
    } batch_t;

endpackage

FILE: hdl/sccw_text_if.sv
// Input channel of the stripper: one raw text byte with lookahead per transfer.
// Depends on nothing but its own signal list.
interface sccw_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic [7:0] next_ch;
    logic       is_last;

    modport source (output valid, ch, next_ch, is_last, input ready);
    modport sink   (input valid, ch, next_ch, is_last, output ready);
endinterface

FILE: hdl/sccw_token_if.sv
// Output channel of the stripper: one token byte or line offset record per transfer.
// Depends on sccw_pkg for the offset width.
interface sccw_token_if;
    logic                             valid;
    logic                             ready;
    logic                             out_kind;
    logic [7:0]                       out_byte;
    logic [sccw_pkg::OUT_OFFSET_W-1:0] out_offset;
    logic                             out_end;

    modport source (output valid, out_kind, out_byte, out_offset, out_end, input ready);
    modport sink   (input valid, out_kind, out_byte, out_offset, out_end, output ready);
endinterface

FILE: hdl/sccw_core.sv
// Scanner state and single-pass decode of one text byte into a batch of results.
// Depends on sccw_pkg.
module sccw_core #(
    parameter int OFFSET_BITS = sccw_pkg::OFFSET_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       ch,
    input  logic [7:0]       next_ch,
    input  logic             is_last,
    output sccw_pkg::batch_t batch
);
    import sccw_pkg::*;

    typedef enum logic [1:0] {CM_NONE, CM_LINE, CM_BLOCK} cmode_t;

    localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

    logic                   skip_reg,  skip_next;
    logic                   psep_reg,  psep_next;
    logic                   quote_reg, quote_next;
    cmode_t                 cm_reg,    cm_next;
    logic [OFFSET_BITS-1:0] cnt_reg,   cnt_next;

    cmode_t                 cm_w;
    logic                   done;
    logic                   emit_sep;
    logic                   emit_chr;
    logic [7:0]             chr;
    logic [OFFSET_BITS-1:0] cnt_a, cnt_m, cnt_e;

    function automatic logic [OFFSET_BITS-1:0] sat_inc(input logic [OFFSET_BITS-1:0] v);
        return (v == COUNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_OFFSET_W-1:0] low_off(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+OUT_OFFSET_W-1:0] wide;
        wide = {{OUT_OFFSET_W{1'b0}}, v};
        return wide[OUT_OFFSET_W-1:0];
    endfunction

    always_comb
    begin
        skip_next  = skip_reg;
        psep_next  = psep_reg;
        quote_next = quote_reg;
        cm_next    = cm_reg;
        cm_w       = cm_reg;
        done       = 1'b0;
        emit_sep   = 1'b0;
        emit_chr   = 1'b0;
        chr        = ch;
        batch      = '0;

        if (skip_reg)
        begin
            skip_next = 1'b0;
        end
        else if (ch == CH_CR || ch == CH_LF)
        begin
            if ((ch == CH_CR && next_ch == CH_LF) || (ch == CH_LF && next_ch == CH_CR))
                skip_next = 1'b1;
            batch.mask[0]         = 1'b1;
            batch.slots[0].kind   = KIND_LINE;
            batch.slots[0].offset = low_off(cnt_reg);
            if (cm_reg == CM_LINE)
                cm_next = CM_NONE;
            psep_next = 1'b1;
        end
        else if (!quote_reg && (ch == CH_SPACE || ch == CH_TAB))
        begin
            psep_next = 1'b1;
        end
        else
        begin
            if (ch == CH_SEMI && cm_w == CM_NONE)
                cm_w = CM_LINE;
            if (ch == CH_SLASH && next_ch == CH_SLASH && cm_w == CM_NONE)
                cm_w = CM_LINE;
            if (ch == CH_SLASH && next_ch == CH_STAR && cm_w == CM_NONE)
            begin
                psep_next = 1'b1;
                cm_w      = CM_BLOCK;
            end
            if (ch == CH_STAR && next_ch == CH_SLASH && cm_w == CM_BLOCK)
            begin
                cm_w      = CM_NONE;
                skip_next = 1'b1;
                done      = 1'b1;
            end
            cm_next = cm_w;
            if (!done && cm_w == CM_NONE)
            begin
                if (psep_reg)
                begin
                    emit_sep  = 1'b1;
                    psep_next = 1'b0;
                end
                if (ch == CH_BSLASH && next_ch == CH_QUOTE)
                begin
                    skip_next = 1'b1;
                    emit_chr  = 1'b1;
                    chr       = CH_QUOTE;
                end
                else if (ch == CH_QUOTE)
                    quote_next = ~quote_reg;
                else
                    emit_chr = 1'b1;
            end
        end

        // separator in slot 0, kept byte in slot 1
        if (emit_sep)
        begin
            batch.mask[0]       = 1'b1;
            batch.slots[0].kind = KIND_BYTE;
            batch.slots[0].data = CH_NUL;
        end
        if (emit_chr)
        begin
            batch.mask[1]       = 1'b1;
            batch.slots[1].kind = KIND_BYTE;
            batch.slots[1].data = chr;
        end

        cnt_a    = emit_sep ? sat_inc(cnt_reg) : cnt_reg;
        cnt_m    = emit_chr ? sat_inc(cnt_a) : cnt_a;
        cnt_e    = sat_inc(cnt_m);
        cnt_next = cnt_m;

        // end of text: 0, closing line offset, 0; then back to reset state
        if (is_last)
        begin
            batch.mask[4:2]       = 3'b111;
            batch.slots[2].kind   = KIND_BYTE;
            batch.slots[2].data   = CH_NUL;
            batch.slots[3].kind   = KIND_LINE;
            batch.slots[3].offset = low_off(cnt_e);
            batch.slots[4].kind   = KIND_BYTE;
            batch.slots[4].data   = CH_NUL;
            skip_next  = 1'b0;
            psep_next  = 1'b0;
            quote_next = 1'b0;
            cm_next    = CM_NONE;
            cnt_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg  <= 1'b0;
            psep_reg  <= 1'b0;
            quote_reg <= 1'b0;
            cm_reg    <= CM_NONE;
            cnt_reg   <= '0;
        end
        else if (take)
        begin
            skip_reg  <= skip_next;
            psep_reg  <= psep_next;
            quote_reg <= quote_next;
            cm_reg    <= cm_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: hdl/sccw_emit.sv
// Result register: holds one byte's batch and delivers its slots one per transfer.
// Depends on sccw_pkg.
module sccw_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  sccw_pkg::batch_t              batch,
    output logic                          free,
    output logic                          valid,
    input  logic                          ready,
    output logic                          out_kind,
    output logic [7:0]                    out_byte,
    output logic [sccw_pkg::OUT_OFFSET_W-1:0] out_offset,
    output logic                          out_end
);
    import sccw_pkg::*;

    logic  [NUM_SLOTS-1:0] mask_reg, mask_next;
    slot_t [NUM_SLOTS-1:0] slots_reg, slots_next;
    logic  [NUM_SLOTS-1:0] pick;
    logic  [NUM_SLOTS-1:0] rest;
    slot_t                 sel;
    logic                  pop;

    always_comb
    begin
        pick = mask_reg & (~mask_reg + 1'b1);   // lowest pending slot
        rest = mask_reg & ~pick;
        sel  = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (pick[i])
                sel = sel | slots_reg[i];
        end
    end

    assign valid      = |mask_reg;
    assign out_kind   = sel.kind;
    assign out_byte   = sel.data;
    assign out_offset = sel.offset;
    assign out_end    = (rest == '0);
    assign pop        = valid && ready;
    assign free       = !valid || (pop && out_end);

    always_comb
    begin
        mask_next  = pop ? rest : mask_reg;
        slots_next = slots_reg;
        if (load)
        begin
            mask_next  = batch.mask;
            slots_next = batch.slots;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= '0;
        else
            mask_reg <= mask_next;
    end

    always_ff @(posedge clk)
    begin
        slots_reg <= slots_next;
    end

endmodule

FILE: hdl/script_comment_whitespace_stripper.sv
// Script comment and whitespace stripper. Each transfer on text carries one
// raw byte, its successor as lookahead (0 after the final byte) and an
// end-of-text flag; tokens delivers a packed token stream: kept bytes, a
// single 0 separator in place of each run of blanks and line breaks, and a
// line start offset record for every line break. ';' and '//' comments run
// to the line end, block comments are dropped, double quotes toggle quote
// mode and vanish, backslash-quote yields a literal quote. After the final
// byte the block sends 0, a closing line offset and 0, and starts afresh.
// Timing: a byte is decoded in the cycle it is taken and its results (0 to
// 5) sit in the result register, leaving one per cycle while tokens.ready
// is high; the next byte is taken in the same cycle as the last result of
// the previous one leaves, or whenever the result register is empty.
// The output rate of one result per cycle while ready is high sets throughput.
// The offset counter is OFFSET_BITS wide and saturates; offsets report its
// low 24 bits.
module script_comment_whitespace_stripper #(
    parameter int OFFSET_BITS = sccw_pkg::OFFSET_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    sccw_text_if.sink     text,
    sccw_token_if.source  tokens
);
    import sccw_pkg::*;

    batch_t batch;
    logic   free;
    logic   take;
    logic   load;

    // a byte is taken when the result register is empty or empties now
    assign text.ready = free;
    assign take       = text.valid && free;
    assign load       = take && (|batch.mask);

    sccw_core #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .ch      (text.ch),
        .next_ch (text.next_ch),
        .is_last (text.is_last),
        .batch   (batch)
    );

    sccw_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .batch      (batch),
        .free       (free),
        .valid      (tokens.valid),
        .ready      (tokens.ready),
        .out_kind   (tokens.out_kind),
        .out_byte   (tokens.out_byte),
        .out_offset (tokens.out_offset),
        .out_end    (tokens.out_end)
    );

endmodule
